// ===== src/csl_pkg.sv =====
// ----------------------------------------------------------------------------
// csl_pkg
// Shared types and constants of the cruise speed limiter: event codes,
// register indexes, Q16.16 limits and the state, register and result structs.
// ----------------------------------------------------------------------------
package csl_pkg;

   // event codes
   localparam logic [3:0] ACT_ACCEL      = 4'd0;
   localparam logic [3:0] ACT_BRAKE      = 4'd1;
   localparam logic [3:0] ACT_CRUISE_ON  = 4'd2;
   localparam logic [3:0] ACT_CRUISE_OFF = 4'd3;
   localparam logic [3:0] ACT_UP         = 4'd4;
   localparam logic [3:0] ACT_DOWN       = 4'd5;
   localparam logic [3:0] ACT_ACTIVATE   = 4'd6;
   localparam logic [3:0] ACT_DEACTIVATE = 4'd7;

   // register indexes
   localparam logic [1:0] CSR_TIME_STEP   = 2'd0;
   localparam logic [1:0] CSR_TARGET_STEP = 2'd1;
   localparam logic [1:0] CSR_BRAKE_DECEL = 2'd2;
   localparam logic [1:0] CSR_OVERSPEED   = 2'd3;

   // register reset values
   localparam logic [15:0] TIME_STEP_RST   = 16'd1101;
   localparam logic [15:0] TARGET_STEP_RST = 16'd328;
   localparam logic [19:0] BRAKE_DECEL_RST = 20'd393216;
   localparam logic [22:0] OVERSPEED_RST   = 23'd2184533;

   localparam logic [22:0] SPEED_MAX      = 23'h7FFFFF;
   localparam logic [19:0] BRAKE_MAG_MAX  = 20'd524288;
   localparam logic [23:0] TARGET_NONE    = 24'hFF0000;

   typedef struct packed {
      logic [22:0]        speed;
      logic signed [19:0] accel;
      logic [22:0]        target;
      logic               brake_latched;
      logic               cruise_on;
      logic               cruise_active;
   } state_type;

   typedef struct packed {
      logic [15:0] time_step;
      logic [15:0] target_step;
      logic [19:0] brake_decel;
      logic [22:0] overspeed_limit;
   } csr_type;

   typedef struct packed {
      logic [22:0]        speed;
      logic signed [23:0] target;
      logic               cruise_on;
      logic               cruise_active;
      logic signed [19:0] accel_now;
      logic               overspeed;
   } result_type;

endpackage

// ===== src/csl_step.sv =====
// ----------------------------------------------------------------------------
// csl_step
// Next state and result for one vehicle event: event decode, target and flag
// update, then one multiply-add speed integration with floor, ceiling and cap.
// ----------------------------------------------------------------------------
module csl_step (
   input  csl_pkg::state_type  state,
   input  csl_pkg::csr_type    csr,
   input  logic [3:0]          action,
   input  logic signed [19:0]  accel_value,
   output csl_pkg::state_type  state_next,
   output csl_pkg::result_type result
);
   import csl_pkg::*;

   state_type          upd;
   logic [19:0]        brake_mag;
   logic [23:0]        target_up;
   logic signed [36:0] product;
   logic signed [36:0] rounded;
   logic signed [20:0] delta;
   logic signed [24:0] speed_sum;
   logic [22:0]        speed_clamped;
   logic [22:0]        speed_new;

   assign brake_mag = (csr.brake_decel > BRAKE_MAG_MAX) ? BRAKE_MAG_MAX : csr.brake_decel;
   assign target_up = {1'b0, state.target} + {8'd0, csr.target_step};

   always_comb begin
      upd = state;
      if (action != ACT_ACCEL) begin
         upd.brake_latched = 1'b0;
      end
      unique case (action)
         ACT_ACCEL: begin
            if (!state.brake_latched) begin
               upd.accel = accel_value;
            end
         end
         ACT_BRAKE: begin
            upd.brake_latched = 1'b1;
            upd.accel         = -$signed(brake_mag);
            upd.cruise_active = 1'b0;
         end
         ACT_CRUISE_ON: begin
            upd.cruise_on = 1'b1;
            upd.target    = state.speed;
         end
         ACT_CRUISE_OFF: begin
            upd.cruise_on = 1'b0;
            upd.target    = '0;
         end
         ACT_UP: begin
            if (state.cruise_on) begin
               upd.target = target_up[23] ? SPEED_MAX : target_up[22:0];
            end
         end
         ACT_DOWN: begin
            if (state.cruise_on) begin
               upd.target = (state.target > {7'd0, csr.target_step}) ?
                            state.target - {7'd0, csr.target_step} : '0;
            end
         end
         ACT_ACTIVATE: begin
            if (state.cruise_on) begin
               upd.cruise_active = 1'b1;
            end
         end
         ACT_DEACTIVATE: begin
            if (state.cruise_on) begin
               upd.cruise_active = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   // Q16.32 product rounded half up to Q16.16
   assign product   = upd.accel * $signed({1'b0, csr.time_step});
   assign rounded   = product + 37'sd32768;
   assign delta     = rounded[36:16];
   assign speed_sum = $signed({2'b00, state.speed}) + {{4{delta[20]}}, delta};

   always_comb begin
      if (speed_sum[24]) begin
         speed_clamped = '0;
      end else if (speed_sum[23]) begin
         speed_clamped = SPEED_MAX;
      end else begin
         speed_clamped = speed_sum[22:0];
      end
      if (upd.cruise_on && upd.cruise_active && (speed_clamped > upd.target)) begin
         speed_new = upd.target;
      end else begin
         speed_new = speed_clamped;
      end
   end

   always_comb begin
      state_next       = upd;
      state_next.speed = speed_new;
   end

   assign result.speed         = speed_new;
   assign result.target        = upd.cruise_on ? $signed({1'b0, upd.target}) : TARGET_NONE;
   assign result.cruise_on     = upd.cruise_on;
   assign result.cruise_active = upd.cruise_active;
   assign result.accel_now     = upd.accel;
   assign result.overspeed     = speed_new > csr.overspeed_limit;

endmodule

// ===== src/cruise_speed_limiter.sv =====
// ----------------------------------------------------------------------------
// cruise_speed_limiter
// Vehicle speed integrator with brake latch and cruise speed capping.
// ----------------------------------------------------------------------------
// One event word is taken per clock while the result side keeps taking words,
// and each gives one result word: the event lands in an input register, then
// one pass of decode and a single 20x17 multiply-add with clamps writes the
// state and the result register together, so the next event sees the updated
// state straight away. The user must write registers through the csr port
// only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module cruise_speed_limiter (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [22:0]        csr_wdata,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [3:0]         req_action,
   input  logic signed [19:0] req_accel_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [22:0]        rsp_speed,
   output logic signed [23:0] rsp_target,
   output logic               rsp_cruise_on,
   output logic               rsp_cruise_active,
   output logic signed [19:0] rsp_accel_now,
   output logic               rsp_overspeed
);
   import csl_pkg::*;

   csr_type            csr_ff;
   state_type          state_ff;
   state_type          state_in;
   result_type         result_in;
   result_type         result_ff;
   logic               in_valid_ff;
   logic [3:0]         action_ff;
   logic signed [19:0] accel_ff;
   logic               rsp_valid_ff;
   logic               advance;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   csl_step u_step (
      .state       (state_ff),
      .csr         (csr_ff),
      .action      (action_ff),
      .accel_value (accel_ff),
      .state_next  (state_in),
      .result      (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.time_step       <= TIME_STEP_RST;
         csr_ff.target_step     <= TARGET_STEP_RST;
         csr_ff.brake_decel     <= BRAKE_DECEL_RST;
         csr_ff.overspeed_limit <= OVERSPEED_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TIME_STEP:   csr_ff.time_step       <= csr_wdata[15:0];
            CSR_TARGET_STEP: csr_ff.target_step     <= csr_wdata[15:0];
            CSR_BRAKE_DECEL: csr_ff.brake_decel     <= csr_wdata[19:0];
            CSR_OVERSPEED:   csr_ff.overspeed_limit <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         action_ff <= req_action;
         accel_ff  <= req_accel_value;
      end
   end

   // state and result register move together
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            state_ff     <= state_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_speed         = result_ff.speed;
   assign rsp_target        = result_ff.target;
   assign rsp_cruise_on     = result_ff.cruise_on;
   assign rsp_cruise_active = result_ff.cruise_active;
   assign rsp_accel_now     = result_ff.accel_now;
   assign rsp_overspeed     = result_ff.overspeed;

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the cruise speed limiter.
// Event words go in over a valid/ready channel and each one is mirrored in a
// local copy of the vehicle state; every result word is compared field by
// field with the oldest predicted reading. Directed event sequences and
// register extremes come first, then a long random drive with register
// changes between phases, random idling on both sides and a receiver
// hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import csl_pkg::*;

   localparam logic [3:0]         ACT_SPARE_LO = 4'd8;
   localparam logic [3:0]         ACT_SPARE_HI = 4'd15;
   localparam logic signed [19:0] ACCEL_MAX    = 20'sh7FFFF;
   localparam logic signed [19:0] ACCEL_MIN    = 20'sh80000;

   logic               clock = 1'b0;
   logic               reset;
   logic               csr_we;
   logic [1:0]         csr_index;
   logic [22:0]        csr_wdata;
   logic               req_valid;
   logic               req_ready;
   logic [3:0]         req_action;
   logic signed [19:0] req_accel_value;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [22:0]        rsp_speed;
   logic signed [23:0] rsp_target;
   logic               rsp_cruise_on;
   logic               rsp_cruise_active;
   logic signed [19:0] rsp_accel_now;
   logic               rsp_overspeed;

   state_type  veh;
   csr_type    regs;
   result_type expected_readings[$];
   int         mismatch_count = 0;
   bit         send_idle = 1'b0;
   bit         recv_idle = 1'b0;
   int         hold_len = 0;

   cruise_speed_limiter u_top (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // one event applied to the local vehicle copy, giving the expected reading
   function automatic result_type step_vehicle(input logic [3:0] act,
                                               input logic signed [19:0] acc);
      longint      delta;
      longint      spd;
      logic [23:0] raised;
      logic [19:0] mag;
      result_type  r;
      if (act != ACT_ACCEL)
         veh.brake_latched = 1'b0;
      case (act)
         ACT_ACCEL: begin
            if (!veh.brake_latched)
               veh.accel = acc;
         end
         ACT_BRAKE: begin
            mag = (regs.brake_decel > BRAKE_MAG_MAX) ? BRAKE_MAG_MAX : regs.brake_decel;
            veh.brake_latched = 1'b1;
            veh.accel = -mag;
            veh.cruise_active = 1'b0;
         end
         ACT_CRUISE_ON: begin
            veh.cruise_on = 1'b1;
            veh.target = veh.speed;
         end
         ACT_CRUISE_OFF: begin
            veh.cruise_on = 1'b0;
            veh.target = '0;
         end
         ACT_UP: begin
            if (veh.cruise_on) begin
               raised = {1'b0, veh.target} + regs.target_step;
               veh.target = (raised > SPEED_MAX) ? SPEED_MAX : raised[22:0];
            end
         end
         ACT_DOWN: begin
            if (veh.cruise_on)
               veh.target = (veh.target > regs.target_step) ?
                            veh.target - regs.target_step : '0;
         end
         ACT_ACTIVATE: begin
            if (veh.cruise_on)
               veh.cruise_active = 1'b1;
         end
         ACT_DEACTIVATE: begin
            if (veh.cruise_on)
               veh.cruise_active = 1'b0;
         end
         default: ;
      endcase
      // q16.32 product rounded to nearest, ties towards plus infinity
      delta = (longint'($signed(veh.accel)) * longint'(regs.time_step) + 32768) >>> 16;
      spd = longint'(veh.speed) + delta;
      if (spd < 0)
         spd = 0;
      if (spd > longint'(SPEED_MAX))
         spd = longint'(SPEED_MAX);
      if (veh.cruise_on && veh.cruise_active && spd > longint'(veh.target))
         spd = longint'(veh.target);
      veh.speed = spd[22:0];
      r.speed = veh.speed;
      r.target = veh.cruise_on ? $signed({1'b0, veh.target}) : $signed(TARGET_NONE);
      r.cruise_on = veh.cruise_on;
      r.cruise_active = veh.cruise_active;
      r.accel_now = veh.accel;
      r.overspeed = veh.speed > regs.overspeed_limit;
      return r;
   endfunction

   task automatic flag_field(input string name, input logic signed [24:0] want,
                             input logic signed [24:0] got);
      if (got !== want) begin
         mismatch_count++;
         $error("%s: expected %0d, actual %0d", name, want, got);
      end
   endtask

   // prediction on accepted event words, comparison on accepted result words
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         veh = '0;
         regs = '{TIME_STEP_RST, TARGET_STEP_RST, BRAKE_DECEL_RST, OVERSPEED_RST};
         expected_readings.delete();
      end else begin
         if (req_valid && req_ready)
            expected_readings.push_back(step_vehicle(req_action, req_accel_value));
         if (rsp_valid && rsp_ready) begin
            if (expected_readings.size() == 0) begin
               mismatch_count++;
               $error("result word with no reading expected");
            end else begin
               want = expected_readings.pop_front();
               flag_field("speed", want.speed, rsp_speed);
               flag_field("target", $signed(want.target), rsp_target);
               flag_field("cruise_on", want.cruise_on, rsp_cruise_on);
               flag_field("cruise_active", want.cruise_active, rsp_cruise_active);
               flag_field("accel_now", $signed(want.accel_now), rsp_accel_now);
               flag_field("overspeed", want.overspeed, rsp_overspeed);
            end
         end
      end
   end

   // result side: random stalls, plus the long hold-off when one is asked for
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_len > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold_len) @(negedge clock);
            hold_len = 0;
         end else if (recv_idle && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_event(input logic [3:0] act, input logic signed [19:0] acc);
      int gap;
      gap = 0;
      if (send_idle && $urandom_range(0, 5) == 0)
         gap = $urandom_range(1, 11);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_accel_value <= acc;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [22:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_TIME_STEP:   regs.time_step = value[15:0];
         CSR_TARGET_STEP: regs.target_step = value[15:0];
         CSR_BRAKE_DECEL: regs.brake_decel = value[19:0];
         CSR_OVERSPEED:   regs.overspeed_limit = value;
         default: ;
      endcase
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_readings.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic signed [19:0] spare_accel();
      return 20'($urandom);
   endfunction

   function automatic logic [3:0] pick_event();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 40) return ACT_ACCEL;
      if (roll < 46) return ACT_BRAKE;
      if (roll < 54) return ACT_CRUISE_ON;
      if (roll < 59) return ACT_CRUISE_OFF;
      if (roll < 69) return ACT_UP;
      if (roll < 79) return ACT_DOWN;
      if (roll < 87) return ACT_ACTIVATE;
      if (roll < 92) return ACT_DEACTIVATE;
      return 4'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
   endfunction

   // mostly forward pedal so that the speed climbs and meets the caps
   function automatic logic signed [19:0] pick_accel();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 45) return 20'($urandom_range(0, 524287));
      if (roll < 75) return 20'($urandom);
      if (roll < 85) return ($urandom_range(0, 1) != 0) ? ACCEL_MAX : ACCEL_MIN;
      return $signed(20'($urandom_range(0, 2047))) - 20'sd1024;
   endfunction

   function automatic logic [22:0] pick_setting(input int unsigned lo, input int unsigned hi);
      case ($urandom_range(0, 3))
         0: return 23'(lo);
         1: return 23'(hi);
         default: return 23'($urandom_range(lo, hi));
      endcase
   endfunction

   task automatic test_event_codes();
      send_event(ACT_CRUISE_ON, spare_accel());    // target taken from a standing start
      send_event(ACT_DOWN, spare_accel());         // target floors at zero
      send_event(ACT_UP, spare_accel());
      send_event(ACT_ACTIVATE, spare_accel());
      send_event(ACT_ACCEL, ACCEL_MAX);            // speed capped at the target
      send_event(ACT_CRUISE_OFF, spare_accel());   // active flag held, cap released
      send_event(ACT_DEACTIVATE, spare_accel());   // no effect while off
      send_event(ACT_UP, spare_accel());
      send_event(ACT_ACCEL, 20'sd0);
      send_event(ACT_CRUISE_ON, spare_accel());
      send_event(ACT_DEACTIVATE, spare_accel());
      send_event(ACT_ACCEL, ACCEL_MAX);
      send_event(ACT_BRAKE, spare_accel());
      send_event(ACT_ACCEL, ACCEL_MAX);            // ignored under the brake latch
      send_event(ACT_ACCEL, ACCEL_MIN);
      send_event(ACT_SPARE_LO, spare_accel());     // unused code only drops the latch
      send_event(ACT_ACCEL, ACCEL_MIN);            // speed floors at zero
      send_event(ACT_BRAKE, spare_accel());
      send_event(ACT_SPARE_HI, spare_accel());
      send_event(ACT_ACCEL, 20'sd0);
      send_event(ACT_ACTIVATE, spare_accel());
      send_event(ACT_CRUISE_OFF, spare_accel());
      wait_idle();
   endtask

   task automatic test_register_extremes();
      write_csr(CSR_TIME_STEP, 23'd65535);
      write_csr(CSR_TARGET_STEP, 23'd65535);
      write_csr(CSR_BRAKE_DECEL, 23'h0FFFFF);      // above the largest brake
      write_csr(CSR_OVERSPEED, 23'd0);
      repeat (17) send_event(ACT_ACCEL, ACCEL_MAX); // speed saturates
      send_event(ACT_CRUISE_ON, spare_accel());
      send_event(ACT_UP, spare_accel());           // target saturates
      send_event(ACT_BRAKE, spare_accel());
      send_event(ACT_SPARE_LO, spare_accel());
      wait_idle();
      write_csr(CSR_TIME_STEP, 23'd0);             // frozen speed
      write_csr(CSR_TARGET_STEP, 23'd0);
      write_csr(CSR_BRAKE_DECEL, 23'd0);
      write_csr(CSR_OVERSPEED, SPEED_MAX);
      send_event(ACT_ACCEL, ACCEL_MAX);
      send_event(ACT_UP, spare_accel());
      send_event(ACT_DOWN, spare_accel());
      send_event(ACT_BRAKE, spare_accel());
      send_event(ACT_DEACTIVATE, spare_accel());
      wait_idle();
      write_csr(CSR_TIME_STEP, 23'(TIME_STEP_RST));
      write_csr(CSR_TARGET_STEP, 23'(TARGET_STEP_RST));
      write_csr(CSR_BRAKE_DECEL, 23'(BRAKE_DECEL_RST));
      write_csr(CSR_OVERSPEED, OVERSPEED_RST);
   endtask

   // result side held off while words keep coming, so the input backs up
   task automatic test_input_stall();
      send_idle = 1'b0;
      recv_idle = 1'b0;
      hold_len = 150;
      repeat (40) send_event(pick_event(), pick_accel());
      wait_idle();
   endtask

   task automatic test_random_drive();
      for (int phase = 0; phase < 6; phase++) begin
         send_idle = (phase % 3) != 2;
         recv_idle = (phase % 2) == 0;
         write_csr(CSR_TIME_STEP, pick_setting(1, 65535));
         write_csr(CSR_TARGET_STEP, pick_setting(1, 65535));
         write_csr(CSR_BRAKE_DECEL, pick_setting(0, 1048575));
         write_csr(CSR_OVERSPEED, pick_setting(0, 8388607));
         repeat (160) send_event(pick_event(), pick_accel());
         wait_idle();
      end
   endtask

   task automatic test_flat_out();
      send_idle = 1'b0;
      recv_idle = 1'b0;
      repeat (150) send_event(pick_event(), pick_accel());
      wait_idle();
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_action = '0;
      req_accel_value = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_event_codes();
      test_register_extremes();
      test_input_stall();
      test_random_drive();
      test_flat_out();

      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #6_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
